/* hw/rtl/dvp_pkg.sv */
// shared types and constants of the dipole vector potential core
// no dependencies; used by dvp_mul and dipole_vector_potential_eval_core
package dvp_pkg;

	localparam int LIMB_W     = 32;
	localparam int GUARD_BITS = 32;
	localparam int PI_FRAC    = 60;
	localparam int QBITS      = 34;
	localparam int CROSS_W    = 64;
	localparam int D2_W       = 66;
	localparam int ROOT_W     = 65;
	localparam int K_W        = 64;

	// round(4*pi * 2^60)
	localparam logic [K_W-1:0] FOUR_PI_Q = 64'hC90FDAA22168C235;

	localparam logic signed [31:0] SOURCE_RST = 32'sd72090;
	localparam logic signed [31:0] MOMENT_RST = 32'sd65536;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SAT      = 2'd1,
		ST_COINCIDE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_SOURCE_X = 3'd0,
		REG_SOURCE_Y = 3'd1,
		REG_SOURCE_Z = 3'd2,
		REG_MOMENT_X = 3'd3,
		REG_MOMENT_Y = 3'd4,
		REG_MOMENT_Z = 3'd5
	} reg_idx_t;

	// per-item data that rides along the root and product pipelines
	typedef struct packed {
		logic [2:0][CROSS_W-1:0] cmag;
		logic [2:0]              cneg;
		logic                    zero;
	} side_t;

endpackage

/* hw/rtl/dvp_mul.sv */
// pipelined wide unsigned multiplier, one 32x32 partial product per stage
// depends on dvp_pkg for the limb width
module dvp_mul #(
	parameter int A_W    = 66,
	parameter int B_W    = 65,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [A_W-1:0]    in_a,
	input  logic [B_W-1:0]    in_b,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [A_W+B_W-1:0] out_p,
	output logic [SIDE_W-1:0] out_side
);

	localparam int LW   = dvp_pkg::LIMB_W;
	localparam int LA   = (A_W + LW - 1) / LW;
	localparam int LB   = (B_W + LW - 1) / LW;
	localparam int NS   = LA * LB;
	localparam int AP_W = LA * LW;
	localparam int BP_W = LB * LW;
	localparam int P_W  = A_W + B_W;

	logic [AP_W-1:0]   a_s    [NS];
	logic [BP_W-1:0]   b_s    [NS];
	logic [P_W-1:0]    acc_s  [NS];
	logic [SIDE_W-1:0] side_s [NS];
	logic              v_s    [NS];

	for (genvar k = 0; k < NS; k++) begin : g_pp
		localparam int IA = k / LB;
		localparam int IB = k % LB;

		logic [AP_W-1:0]   a_in;
		logic [BP_W-1:0]   b_in;
		logic [P_W-1:0]    acc_in;
		logic [SIDE_W-1:0] side_in;
		logic              v_in;
		logic [2*LW-1:0]   pp;

		if (k == 0) begin : g_head
			assign a_in    = AP_W'(in_a);
			assign b_in    = BP_W'(in_b);
			assign acc_in  = '0;
			assign side_in = in_side;
			assign v_in    = in_valid;
		end else begin : g_body
			assign a_in    = a_s[k-1];
			assign b_in    = b_s[k-1];
			assign acc_in  = acc_s[k-1];
			assign side_in = side_s[k-1];
			assign v_in    = v_s[k-1];
		end

		assign pp = a_in[IA*LW +: LW] * b_in[IB*LW +: LW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			a_s[k]    <= a_in;
			b_s[k]    <= b_in;
			side_s[k] <= side_in;
			acc_s[k]  <= acc_in + (P_W'(pp) << (LW * (IA + IB)));
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_p     = acc_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

/* hw/rtl/dipole_vector_potential_eval_core.sv */
// dipole vector potential core: A = (m x r) / (4*pi*|r|^3) in signed fixed point
// depends on dvp_pkg and dvp_mul
//
// channel   direction  handshake          payload
// config    in/out     psel/penable/pwrite paddr, pwdata, prdata (apb, pready high)
// point     in         start, busy        point_x, point_y, point_z
// field     out        done               field_x, field_y, field_z, status
//
// one point word accepted per clock; busy never rises
// stages from the accepting edge to the edge that takes the result:
// offset, products, cross/sum (3), bitwise square root (65), d2*root
// product (9), times 4*pi product (10), long division (35), output (1)
// reset clears the valid bits and loads the register defaults
// done marks each result for one clock; the receiver cannot stall
module dipole_vector_potential_eval_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// point word
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	// field word
	output logic               done,
	output logic signed [31:0] field_x,
	output logic signed [31:0] field_y,
	output logic signed [31:0] field_z,
	output logic [1:0]         status
);

	localparam int QB    = dvp_pkg::QBITS;
	localparam int RW    = dvp_pkg::ROOT_W;
	localparam int D2W   = dvp_pkg::D2_W;
	localparam int CW    = dvp_pkg::CROSS_W;
	localparam int M1_W  = D2W + RW;
	localparam int WD    = M1_W + dvp_pkg::K_W;
	// numerator carries 2F + 60 + 32 fraction bits plus one for rounding;
	// the top part above the quotient bits starts the division
	localparam int SH    = 2 * FRAC_BITS + dvp_pkg::PI_FRAC + dvp_pkg::GUARD_BITS + 1 - QB;
	localparam int WP0   = CW + SH;
	localparam int WCMP  = (WP0 > WD) ? WP0 : WD;
	localparam int SIDE_W = $bits(dvp_pkg::side_t);
	localparam logic [QB-1:0] LIM_POS = QB'(32'h7FFFFFFF);
	localparam logic [QB-1:0] LIM_NEG = QB'(32'h80000000);

	// configuration registers
	logic signed [31:0] src_q [3];
	logic signed [31:0] mom_q [3];
	dvp_pkg::reg_idx_t  reg_idx;
	logic               cfg_wr;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_idx = dvp_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				src_q[i] <= dvp_pkg::SOURCE_RST;
				mom_q[i] <= dvp_pkg::MOMENT_RST;
			end
		end else if (cfg_wr) begin
			unique case (reg_idx)
				dvp_pkg::REG_SOURCE_X: src_q[0] <= pwdata;
				dvp_pkg::REG_SOURCE_Y: src_q[1] <= pwdata;
				dvp_pkg::REG_SOURCE_Z: src_q[2] <= pwdata;
				dvp_pkg::REG_MOMENT_X: mom_q[0] <= pwdata;
				dvp_pkg::REG_MOMENT_Y: mom_q[1] <= pwdata;
				dvp_pkg::REG_MOMENT_Z: mom_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dvp_pkg::REG_SOURCE_X: prdata = src_q[0];
			dvp_pkg::REG_SOURCE_Y: prdata = src_q[1];
			dvp_pkg::REG_SOURCE_Z: prdata = src_q[2];
			dvp_pkg::REG_MOMENT_X: prdata = mom_q[0];
			dvp_pkg::REG_MOMENT_Y: prdata = mom_q[1];
			dvp_pkg::REG_MOMENT_Z: prdata = mom_q[2];
			default:               prdata = '0;
		endcase
	end

	// front end: offset, products, cross product and squared distance
	logic               v_s1, v_s2, v_s3;
	logic signed [32:0] r_s1     [3];
	logic signed [64:0] pr_s2    [6];
	logic signed [65:0] sq_s2    [3];
	logic               zero_s2, zero_s3;
	logic signed [65:0] cross_s3 [3];
	logic [D2W-1:0]     d2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			r_s1[0] <= 33'(point_x) - 33'(src_q[0]);
			r_s1[1] <= 33'(point_y) - 33'(src_q[1]);
			r_s1[2] <= 33'(point_z) - 33'(src_q[2]);
		end
		// x = my*rz - mz*ry, y = mz*rx - mx*rz, z = mx*ry - my*rx
		pr_s2[0] <= mom_q[1] * r_s1[2];
		pr_s2[1] <= mom_q[2] * r_s1[1];
		pr_s2[2] <= mom_q[2] * r_s1[0];
		pr_s2[3] <= mom_q[0] * r_s1[2];
		pr_s2[4] <= mom_q[0] * r_s1[1];
		pr_s2[5] <= mom_q[1] * r_s1[0];
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= r_s1[i] * r_s1[i];
		end
		zero_s2 <= (r_s1[0] == '0) && (r_s1[1] == '0) && (r_s1[2] == '0);

		for (int i = 0; i < 3; i++) begin
			cross_s3[i] <= pr_s2[2*i] - pr_s2[2*i+1];
		end
		d2_s3 <= D2W'(sq_s2[0][63:0]) + D2W'(sq_s2[1][63:0]) + D2W'(sq_s2[2][63:0]);
		zero_s3 <= zero_s2;
	end

	// sign and magnitude of the cross product, entering the root pipeline
	dvp_pkg::side_t side_in;

	always_comb begin
		logic signed [65:0] mag;
		mag = '0;
		for (int i = 0; i < 3; i++) begin
			mag = cross_s3[i][65] ? -cross_s3[i] : cross_s3[i];
			side_in.cneg[i] = cross_s3[i][65];
			side_in.cmag[i] = mag[CW-1:0];
		end
		side_in.zero = zero_s3;
	end

	// bitwise square root of d2 * 2^64, one root bit per stage
	logic [68:0]         sq_rem_s  [RW];
	logic [RW-1:0]       sq_root_s [RW];
	logic [D2W-1:0]      sq_d2_s   [RW];
	dvp_pkg::side_t      sq_side_s [RW];
	logic                sq_v_s    [RW];

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		localparam int XB = 2 * (RW - 1 - k);

		logic [68:0]          rem_in;
		logic [RW-1:0]        root_in;
		logic [D2W-1:0]       d2_in;
		dvp_pkg::side_t       side_k;
		logic                 v_in;
		logic [2*RW-1:0]      xw;
		logic [68:0]          remsh;
		logic [68:0]          trial;

		if (k == 0) begin : g_head
			assign rem_in  = '0;
			assign root_in = '0;
			assign d2_in   = d2_s3;
			assign side_k  = side_in;
			assign v_in    = v_s3;
		end else begin : g_body
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign d2_in   = sq_d2_s[k-1];
			assign side_k  = sq_side_s[k-1];
			assign v_in    = sq_v_s[k-1];
		end

		assign xw    = {d2_in, {(2*dvp_pkg::GUARD_BITS){1'b0}}};
		assign remsh = {rem_in[66:0], xw[XB+1:XB]};
		assign trial = {2'b00, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else begin
				sq_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (remsh >= trial) begin
				sq_rem_s[k]  <= remsh - trial;
				sq_root_s[k] <= {root_in[RW-2:0], 1'b1};
			end else begin
				sq_rem_s[k]  <= remsh;
				sq_root_s[k] <= {root_in[RW-2:0], 1'b0};
			end
			sq_d2_s[k]   <= d2_in;
			sq_side_s[k] <= side_k;
		end
	end

	// divisor 4*pi * d2 * root
	logic              m1_v, m2_v;
	logic [M1_W-1:0]   m1_p;
	logic [WD-1:0]     m2_d;
	logic [SIDE_W-1:0] m1_side, m2_side_raw;
	dvp_pkg::side_t    m2_side;

	dvp_mul #(
		.A_W    (D2W),
		.B_W    (RW),
		.SIDE_W (SIDE_W)
	) u_mul_dr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_v_s[RW-1]),
		.in_a      (sq_d2_s[RW-1]),
		.in_b      (sq_root_s[RW-1]),
		.in_side   (sq_side_s[RW-1]),
		.out_valid (m1_v),
		.out_p     (m1_p),
		.out_side  (m1_side)
	);

	dvp_mul #(
		.A_W    (M1_W),
		.B_W    (dvp_pkg::K_W),
		.SIDE_W (SIDE_W)
	) u_mul_k (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m1_v),
		.in_a      (m1_p),
		.in_b      (dvp_pkg::FOUR_PI_Q),
		.in_side   (m1_side),
		.out_valid (m2_v),
		.out_p     (m2_d),
		.out_side  (m2_side_raw)
	);

	assign m2_side = m2_side_raw;

	// restoring division, twice the quotient for rounding, one bit per stage
	logic [WD-1:0]   dv_p_s    [QB+1][3];
	logic [QB-1:0]   dv_q_s    [QB+1][3];
	logic [2:0]      dv_ovf_s  [QB+1];
	logic [2:0]      dv_neg_s  [QB+1];
	logic            dv_zero_s [QB+1];
	logic [WD-1:0]   dv_d_s    [QB+1];
	logic            dv_v_s    [QB+1];
	logic [WCMP-1:0] p0_ext    [3];
	logic [2:0]      ovf0;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p0_ext[i] = WCMP'(m2_side.cmag[i]) << SH;
			// quotient would need more than QB bits
			ovf0[i]   = p0_ext[i] >= WCMP'(m2_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= m2_v;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_p_s[0][i] <= ovf0[i] ? '0 : p0_ext[i][WD-1:0];
			dv_q_s[0][i] <= '0;
		end
		dv_ovf_s[0]  <= ovf0;
		dv_neg_s[0]  <= m2_side.cneg;
		dv_zero_s[0] <= m2_side.zero;
		dv_d_s[0]    <= m2_d;
	end

	for (genvar j = 1; j <= QB; j++) begin : g_div
		logic [WD:0] t [3];
		logic [2:0]  ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i]  = {dv_p_s[j-1][i], 1'b0};
				ge[i] = t[i] >= {1'b0, dv_d_s[j-1]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else begin
				dv_v_s[j] <= dv_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				dv_p_s[j][i] <= ge[i] ? WD'(t[i] - {1'b0, dv_d_s[j-1]}) : t[i][WD-1:0];
				dv_q_s[j][i] <= {dv_q_s[j-1][i][QB-2:0], ge[i]};
			end
			dv_ovf_s[j]  <= dv_ovf_s[j-1];
			dv_neg_s[j]  <= dv_neg_s[j-1];
			dv_zero_s[j] <= dv_zero_s[j-1];
			dv_d_s[j]    <= dv_d_s[j-1];
		end
	end

	// round half away, saturate, apply sign, zero a coincident point and set the status
	logic signed [31:0] fv [3];
	logic [2:0]         sat;
	dvp_pkg::status_t   st;

	always_comb begin
		logic [QB:0]   qi;
		logic [QB-1:0] mag;
		logic [QB-1:0] lim;
		logic [QB-1:0] val;
		qi  = '0;
		mag = '0;
		lim = '0;
		val = '0;
		for (int i = 0; i < 3; i++) begin
			qi     = {1'b0, dv_q_s[QB][i]} + (QB+1)'(1);
			mag    = qi[QB:1];
			lim    = dv_neg_s[QB][i] ? LIM_NEG : LIM_POS;
			sat[i] = dv_ovf_s[QB][i] || (mag > lim);
			val    = sat[i] ? lim : mag;
			fv[i]  = dv_neg_s[QB][i] ? (32'sd0 - signed'(val[31:0])) : signed'(val[31:0]);
		end
		if (dv_zero_s[QB]) begin
			st = dvp_pkg::ST_COINCIDE;
			for (int i = 0; i < 3; i++) begin
				fv[i] = '0;
			end
		end else if (|sat) begin
			st = dvp_pkg::ST_SAT;
		end else begin
			st = dvp_pkg::ST_OK;
		end
	end

	logic signed [31:0] field_q [3];
	dvp_pkg::status_t   status_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			field_q[i] <= fv[i];
		end
		status_q <= st;
	end

	assign done    = done_q;
	assign field_x = field_q[0];
	assign field_y = field_q[1];
	assign field_z = field_q[2];
	assign status  = status_q;

endmodule

/* sim/dipole_vector_potential_eval_core_test.sv */
// self-checking testbench of dipole_vector_potential_eval_core: apb register setup,
// directed and random point words, predicted fields compared at the done strobe
// depends on dvp_pkg and the core rtl
module dipole_vector_potential_eval_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC     = 16;
	localparam int LATENCY  = 123;
	localparam int N_RANDOM = 1800;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic               done;
	logic signed [31:0] field_x;
	logic signed [31:0] field_y;
	logic signed [31:0] field_z;
	logic [1:0]         status;

	int errors = 0;

	dipole_vector_potential_eval_core #(.FRAC_BITS(FRAC)) dut (.*);

	// 12 ns period
	always #6 clk = ~clk;

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	typedef struct {
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
		logic [1:0]  st;
	} field_word_t;

	// holds its own copy of the registers and the fields still on their way
	class field_scoreboard;
		logic signed [31:0] cfg[6];
		field_word_t        pending[$];

		function new();
			cfg[dvp_pkg::REG_SOURCE_X] = dvp_pkg::SOURCE_RST;
			cfg[dvp_pkg::REG_SOURCE_Y] = dvp_pkg::SOURCE_RST;
			cfg[dvp_pkg::REG_SOURCE_Z] = dvp_pkg::SOURCE_RST;
			cfg[dvp_pkg::REG_MOMENT_X] = dvp_pkg::MOMENT_RST;
			cfg[dvp_pkg::REG_MOMENT_Y] = dvp_pkg::MOMENT_RST;
			cfg[dvp_pkg::REG_MOMENT_Z] = dvp_pkg::MOMENT_RST;
		endfunction

		// signed 128-bit a*b - c*d, exact for the operand widths here
		function automatic logic signed [127:0] cross_term(logic signed [127:0] a,
				logic signed [127:0] b, logic signed [127:0] c, logic signed [127:0] d);
			return a * b - c * d;
		endfunction

		function void note(logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] pz);
			logic signed [127:0] r[3];
			logic signed [127:0] m[3];
			logic signed [127:0] c[3];
			logic [255:0] d2, x, root, cand, den, num, q, rem, mag, lim, cm;
			field_word_t w;
			logic [31:0] comp[3];
			logic neg;
			r[0] = 128'(px) - 128'(cfg[dvp_pkg::REG_SOURCE_X]);
			r[1] = 128'(py) - 128'(cfg[dvp_pkg::REG_SOURCE_Y]);
			r[2] = 128'(pz) - 128'(cfg[dvp_pkg::REG_SOURCE_Z]);
			m[0] = 128'(cfg[dvp_pkg::REG_MOMENT_X]);
			m[1] = 128'(cfg[dvp_pkg::REG_MOMENT_Y]);
			m[2] = 128'(cfg[dvp_pkg::REG_MOMENT_Z]);
			w.st = dvp_pkg::ST_OK;
			if (r[0] == 0 && r[1] == 0 && r[2] == 0) begin
				// point on the source: zero field
				w.fx = '0; w.fy = '0; w.fz = '0; w.st = dvp_pkg::ST_COINCIDE;
				pending = {pending, w};
				return;
			end
			c[0] = cross_term(m[1], r[2], m[2], r[1]);
			c[1] = cross_term(m[2], r[0], m[0], r[2]);
			c[2] = cross_term(m[0], r[1], m[1], r[0]);
			d2 = '0;
			for (int i = 0; i < 3; i++)
				d2 += 256'(r[i] * r[i]);
			// floor(sqrt(d2 * 2^64)), bit by bit
			x = d2 << 64;
			root = '0;
			for (int b = 65; b >= 0; b--) begin
				cand = root | (256'd1 << b);
				if (cand * cand <= x)
					root = cand;
			end
			den = 256'(dvp_pkg::FOUR_PI_Q) * d2 * root;
			for (int i = 0; i < 3; i++) begin
				neg = c[i] < 0;
				cm = neg ? 256'(-c[i]) : 256'(c[i]);
				num = cm << (2 * FRAC + dvp_pkg::PI_FRAC + dvp_pkg::GUARD_BITS);
				q = num / den;
				rem = num - q * den;
				// round half away from zero on the magnitude
				if ((rem << 1) >= den)
					q = q + 1;
				lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
				mag = q;
				if (mag > lim) begin
					mag = lim;
					w.st = dvp_pkg::ST_SAT;
				end
				comp[i] = neg ? 32'(-mag) : mag[31:0];
			end
			w.fx = comp[0]; w.fy = comp[1]; w.fz = comp[2];
			pending = {pending, w};
		endfunction

		task check(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
				logic [1:0] st);
			field_word_t e;
			if (pending.size() == 0) begin
				report("field word with no point outstanding");
				return;
			end
			e = pending.pop_front();
			if (fx !== e.fx)
				report($sformatf("field_x %h expected %h", fx, e.fx));
			if (fy !== e.fy)
				report($sformatf("field_y %h expected %h", fy, e.fy));
			if (fz !== e.fz)
				report($sformatf("field_z %h expected %h", fz, e.fz));
			if (st !== e.st)
				report($sformatf("status %0d expected %0d", st, e.st));
		endtask
	endclass

	field_scoreboard sb = new();

	// accepted points and produced fields, both sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note(point_x, point_y, point_z);
		if (arst_n && done)
			sb.check(field_x, field_y, field_z, status);
	end

	// apb write: setup cycle then access cycle, pready is always high
	task automatic write_reg(input dvp_pkg::reg_idx_t idx, input logic signed [31:0] value);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = 5'(4 * idx); pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.cfg[idx] = value;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// registers only change once every field is back and the pipe has drained
	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic set_config(input logic signed [31:0] sx, sy, sz, mx, my, mz);
		drain();
		write_reg(dvp_pkg::REG_SOURCE_X, sx);
		write_reg(dvp_pkg::REG_SOURCE_Y, sy);
		write_reg(dvp_pkg::REG_SOURCE_Z, sz);
		write_reg(dvp_pkg::REG_MOMENT_X, mx);
		write_reg(dvp_pkg::REG_MOMENT_Y, my);
		write_reg(dvp_pkg::REG_MOMENT_Z, mz);
	endtask

	// start stays high across back-to-back words; it drops only for a gap or in stop_points
	bit gaps_on = 1'b1;

	task automatic send_point(input logic signed [31:0] x, y, z);
		int gap;
		gap = gaps_on ? $urandom_range(0, 12) : 0;
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		point_x = x; point_y = y; point_z = z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic stop_points();
		@(negedge clk);
		start = 1'b0;
	endtask

	// random magnitude spread over all scales, random sign
	function automatic logic signed [31:0] rand_span();
		logic [31:0] v;
		v = $urandom >> $urandom_range(0, 31);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// mostly points near the source, some far, a few on it
	task automatic send_random();
		int kind;
		kind = $urandom_range(0, 19);
		if (kind == 0)
			send_point(sb.cfg[dvp_pkg::REG_SOURCE_X], sb.cfg[dvp_pkg::REG_SOURCE_Y],
				sb.cfg[dvp_pkg::REG_SOURCE_Z]);
		else if (kind < 6)
			send_point($urandom, $urandom, $urandom);
		else
			send_point(sb.cfg[dvp_pkg::REG_SOURCE_X] + rand_span(),
				sb.cfg[dvp_pkg::REG_SOURCE_Y] + rand_span(),
				sb.cfg[dvp_pkg::REG_SOURCE_Z] + rand_span());
	endtask

	localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S_RST = dvp_pkg::SOURCE_RST;
	localparam logic signed [31:0] M_RST = dvp_pkg::MOMENT_RST;

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: coincident point, cross product zero on the diagonal
		send_point(S_RST, S_RST, S_RST);
		send_point(S_RST + 32'sd65536, S_RST + 32'sd65536, S_RST + 32'sd65536);
		send_point(S_RST + 32'sd1, S_RST, S_RST);
		send_point(S_RST - 32'sd1, S_RST, S_RST);
		send_point(S_RST, S_RST + 32'sd131072, S_RST);
		send_point(S_MAX, S_MAX, S_MAX);
		send_point(S_MIN, S_MIN, S_MIN);
		send_point(S_MAX, S_MIN, 32'sd0);
		send_point(32'sd0, 32'sd0, 32'sd0);
		stop_points();

		// extremes: source at the negative corner, largest moments
		set_config(S_MIN, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX);
		send_point(S_MAX, S_MAX, S_MAX);
		send_point(S_MAX, S_MIN, S_MIN);
		send_point(S_MIN + 32'sd1, S_MIN, S_MIN);
		send_point(S_MIN, S_MIN, S_MIN);
		send_point(32'sd0, S_MAX, S_MIN);
		stop_points();

		set_config(S_MAX, 32'sd0, S_MIN, S_MIN, S_MIN, S_MIN);
		send_point(S_MIN, S_MAX, S_MAX);
		send_point(S_MAX, 32'sd1, S_MIN);
		send_point(32'sd0, 32'sd0, 32'sd0);
		stop_points();

		// zero moment: every component zero without a flag
		set_config(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_point(32'sd65536, 32'sd0, 32'sd0);
		send_point(S_MAX, S_MIN, S_MAX);
		stop_points();

		// random phases under several register settings
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5)
				set_config(S_RST, S_RST, S_RST, M_RST, M_RST, M_RST);
			else
				set_config($urandom, $urandom, $urandom,
					rand_span(), rand_span(), rand_span());
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				// runs of back-to-back words between gappy stretches
				if (i % 50 == 0)
					gaps_on = $urandom_range(0, 2) != 0;
				send_random();
			end
			stop_points();
		end

		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/dvp_pkg.sv
hw/rtl/dvp_mul.sv
hw/rtl/dipole_vector_potential_eval_core.sv
sim/dipole_vector_potential_eval_core_test.sv
